### rtl/vfc_pkg.sv
// Shared types, codes and constants for the voxel face culling block.
// Used by vfc_addr_gen, voxel_face_cull_top and the testbench; depends on nothing.
package vfc_pkg;

   // Default grid dimensions.
   localparam int DEF_SIZE_X = 16;
   localparam int DEF_SIZE_Y = 8;
   localparam int DEF_SIZE_Z = 16;

   // Coordinate arithmetic width: holds any coordinate, its neighbours and 256.
   localparam int COORD_W    = 9;
   // Width of the row address calculation before it is cut to the memory depth.
   localparam int ROW_CALC_W = 2 * COORD_W;

   localparam int FACE_W = 6;

   // Request action codes.
   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_ADD   = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   // Neighbour read steps of a query.
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_CENTRE = 3'd0;
   localparam logic [STEP_W-1:0] STEP_ZP     = 3'd1;
   localparam logic [STEP_W-1:0] STEP_ZN     = 3'd2;
   localparam logic [STEP_W-1:0] STEP_YP     = 3'd3;
   localparam logic [STEP_W-1:0] STEP_YN     = 3'd4;

   // Bit positions of the faces in the visibility mask.
   localparam int FACE_ZP = 0;
   localparam int FACE_XP = 1;
   localparam int FACE_ZN = 2;
   localparam int FACE_XN = 3;
   localparam int FACE_YP = 4;
   localparam int FACE_YN = 5;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_ADD_READ,
      ST_ADD_WRITE,
      ST_QUERY,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Row address and column selects for one step, with in-grid flags.
   typedef struct packed {
      logic [ROW_CALC_W-1:0] row;
      logic [COORD_W-1:0]    col_self;
      logic [COORD_W-1:0]    col_a;
      logic [COORD_W-1:0]    col_b;
      logic                  hit_self;
      logic                  hit_a;
      logic                  hit_b;
   } nbr_type;

endpackage

### rtl/vfc_addr_gen.sv
// Neighbour address generator: maps a cell and a read step to a row address
// of the occupancy memory and the columns to test. Depends on vfc_pkg.
module vfc_addr_gen #(
   parameter int SIZE_X = vfc_pkg::DEF_SIZE_X,
   parameter int SIZE_Y = vfc_pkg::DEF_SIZE_Y,
   parameter int SIZE_Z = vfc_pkg::DEF_SIZE_Z
) (
   input  logic [3:0]                  x_coord,
   input  logic [2:0]                  y_coord,
   input  logic [3:0]                  z_coord,
   input  logic [vfc_pkg::STEP_W-1:0]  step,
   output vfc_pkg::nbr_type            nbr
);

   logic [vfc_pkg::COORD_W-1:0] xe, ye, ze;
   logic [vfc_pkg::COORD_W-1:0] lim_x, lim_y, lim_z;
   logic [vfc_pkg::COORD_W-1:0] ny, nz;
   logic [vfc_pkg::COORD_W-1:0] one;
   logic                        x_in, y_in, z_in;

   assign one   = vfc_pkg::COORD_W'(1);
   assign xe    = vfc_pkg::COORD_W'(x_coord);
   assign ye    = vfc_pkg::COORD_W'(y_coord);
   assign ze    = vfc_pkg::COORD_W'(z_coord);
   assign lim_x = vfc_pkg::COORD_W'(SIZE_X);
   assign lim_y = vfc_pkg::COORD_W'(SIZE_Y);
   assign lim_z = vfc_pkg::COORD_W'(SIZE_Z);
   assign x_in  = xe < lim_x;
   assign y_in  = ye < lim_y;
   assign z_in  = ze < lim_z;

   // Pick the neighbour row for this step. Cells beyond the grid edge never hit.
   always_comb begin
      ny           = ye;
      nz           = ze;
      nbr.col_self = xe;
      nbr.hit_self = x_in && y_in && z_in;
      nbr.col_a    = xe;
      nbr.col_b    = xe;
      nbr.hit_a    = 1'b0;
      nbr.hit_b    = 1'b0;
      case (step)
         vfc_pkg::STEP_CENTRE: begin
            // The own row serves both x neighbours.
            nbr.col_a = xe + one;
            nbr.col_b = xe - one;
            nbr.hit_a = y_in && z_in && ((xe + one) < lim_x);
            nbr.hit_b = y_in && z_in && (xe != '0) && ((xe - one) < lim_x);
         end
         vfc_pkg::STEP_ZP: begin
            nz        = ze + one;
            nbr.hit_a = x_in && y_in && ((ze + one) < lim_z);
         end
         vfc_pkg::STEP_ZN: begin
            nz        = ze - one;
            nbr.hit_a = x_in && y_in && (ze != '0) && ((ze - one) < lim_z);
         end
         vfc_pkg::STEP_YP: begin
            ny        = ye + one;
            nbr.hit_a = x_in && z_in && ((ye + one) < lim_y);
         end
         vfc_pkg::STEP_YN: begin
            ny        = ye - one;
            nbr.hit_a = x_in && z_in && (ye != '0) && ((ye - one) < lim_y);
         end
         default: begin
            nbr.hit_a = 1'b0;
         end
      endcase
      nbr.row = vfc_pkg::ROW_CALC_W'(nz) * vfc_pkg::ROW_CALC_W'(SIZE_Y)
              + vfc_pkg::ROW_CALC_W'(ny);
   end

endmodule

### rtl/vfc_row_mem.sv
// Occupancy memory: one row of x cells per (y, z) pair, one write port and
// one read port with registered read data. Depends on nothing.
module vfc_row_mem #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 16,
   parameter int AW    = 7
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] row_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= row_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/voxel_face_cull_top.sv
// Voxel face culling: occupancy map of opaque blocks with face visibility queries.
// A query's five row reads share one read port: it steps through the reads, a drain
// state and a finish state before the next request is taken. A transparent query goes
// straight to finish, an add reads its row and writes it back, an unused action is
// ignored, and a stalled result holds a query in finish. A clear sweeps one row a
// cycle; after reset the same sweep empties the map before the first request is taken.
module voxel_face_cull_top #(
   parameter int SIZE_X = vfc_pkg::DEF_SIZE_X,
   parameter int SIZE_Y = vfc_pkg::DEF_SIZE_Y,
   parameter int SIZE_Z = vfc_pkg::DEF_SIZE_Z
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_action,
   input  logic [3:0]                  req_x_coord,
   input  logic [2:0]                  req_y_coord,
   input  logic [3:0]                  req_z_coord,
   input  logic                        req_transparent,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [vfc_pkg::FACE_W-1:0]  rsp_face_visible
);

   localparam int ROWS   = SIZE_Y * SIZE_Z;
   localparam int ROW_AW = $clog2(ROWS);
   localparam int COL_W  = $clog2(SIZE_X);

   vfc_pkg::state_type             state_ff, state_in;
   logic [ROW_AW-1:0]              sweep_ff, sweep_in;
   logic [vfc_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [3:0]                     item_x_ff, item_x_in;
   logic [2:0]                     item_y_ff, item_y_in;
   logic [3:0]                     item_z_ff, item_z_in;
   logic                           item_transp_ff, item_transp_in;
   logic                           rd_pend_ff, rd_pend_in;
   logic [vfc_pkg::STEP_W-1:0]     rd_step_ff;
   vfc_pkg::nbr_type               rd_info_ff;
   logic [vfc_pkg::FACE_W-1:0]     occ_ff, occ_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [vfc_pkg::FACE_W-1:0]     rsp_face_ff, rsp_face_in;

   logic                           accept;
   logic                           last_row;
   logic                           slot_free;
   logic                           rsp_load;
   logic                           start_query;
   vfc_pkg::nbr_type               nbr;
   logic [ROW_AW-1:0]              nbr_row;
   logic                           mem_wr_en, mem_rd_en;
   logic [ROW_AW-1:0]              mem_wr_addr;
   logic [SIZE_X-1:0]              mem_wr_data;
   logic [SIZE_X-1:0]              rd_data;
   logic [SIZE_X-1:0]              row_mod;
   logic                           occ_a, occ_b;

   assign accept      = req_valid && !req_stall;
   assign last_row    = sweep_ff == ROW_AW'(ROWS - 1);
   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign start_query = accept && (req_action == vfc_pkg::ACT_QUERY);
   assign nbr_row     = nbr.row[ROW_AW-1:0];

   // Neighbour addressing for the request held in the item registers.
   vfc_addr_gen #(
      .SIZE_X (SIZE_X),
      .SIZE_Y (SIZE_Y),
      .SIZE_Z (SIZE_Z)
   ) u_addr_gen (
      .x_coord (item_x_ff),
      .y_coord (item_y_ff),
      .z_coord (item_z_ff),
      .step    (step_ff),
      .nbr     (nbr)
   );

   vfc_row_mem #(
      .DEPTH (ROWS),
      .WIDTH (SIZE_X),
      .AW    (ROW_AW)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (nbr_row),
      .rd_data (rd_data)
   );

   // Row with the added cell updated, written back after the read.
   always_comb begin
      row_mod = rd_data;
      row_mod[nbr.col_self[COL_W-1:0]] = !item_transp_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vfc_pkg::ST_SWEEP: begin
            if (last_row) state_in = vfc_pkg::ST_IDLE;
         end
         vfc_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  vfc_pkg::ACT_CLEAR: state_in = vfc_pkg::ST_SWEEP;
                  vfc_pkg::ACT_ADD:   state_in = vfc_pkg::ST_ADD_READ;
                  vfc_pkg::ACT_QUERY: state_in = req_transparent ? vfc_pkg::ST_FINISH
                                                                 : vfc_pkg::ST_QUERY;
                  default:            state_in = vfc_pkg::ST_IDLE;
               endcase
            end
         end
         vfc_pkg::ST_ADD_READ: begin
            state_in = nbr.hit_self ? vfc_pkg::ST_ADD_WRITE : vfc_pkg::ST_IDLE;
         end
         vfc_pkg::ST_ADD_WRITE: begin
            state_in = vfc_pkg::ST_IDLE;
         end
         vfc_pkg::ST_QUERY: begin
            if (step_ff == vfc_pkg::STEP_YN) state_in = vfc_pkg::ST_DRAIN;
         end
         vfc_pkg::ST_DRAIN: begin
            state_in = vfc_pkg::ST_FINISH;
         end
         vfc_pkg::ST_FINISH: begin
            if (slot_free) state_in = vfc_pkg::ST_IDLE;
         end
         default: begin
            state_in = vfc_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs: handshake, memory port controls and result load.
   always_comb begin
      req_stall   = state_ff != vfc_pkg::ST_IDLE;
      mem_wr_en   = 1'b0;
      mem_wr_addr = nbr_row;
      mem_wr_data = row_mod;
      mem_rd_en   = 1'b0;
      rd_pend_in  = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         vfc_pkg::ST_SWEEP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_ff;
            mem_wr_data = '0;
         end
         vfc_pkg::ST_ADD_READ: begin
            mem_rd_en = nbr.hit_self;
         end
         vfc_pkg::ST_ADD_WRITE: begin
            mem_wr_en = 1'b1;
         end
         vfc_pkg::ST_QUERY: begin
            mem_rd_en  = nbr.hit_a || nbr.hit_b;
            rd_pend_in = nbr.hit_a || nbr.hit_b;
         end
         vfc_pkg::ST_FINISH: begin
            rsp_load = slot_free;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // Counters and the held request.
   always_comb begin
      sweep_in       = sweep_ff;
      step_in        = step_ff;
      item_x_in      = item_x_ff;
      item_y_in      = item_y_ff;
      item_z_in      = item_z_ff;
      item_transp_in = item_transp_ff;
      if (state_ff == vfc_pkg::ST_SWEEP) begin
         sweep_in = sweep_ff + ROW_AW'(1);
      end
      if (state_ff == vfc_pkg::ST_QUERY) begin
         step_in = step_ff + vfc_pkg::STEP_W'(1);
      end
      if (accept) begin
         sweep_in       = '0;
         step_in        = vfc_pkg::STEP_CENTRE;
         item_x_in      = req_x_coord;
         item_y_in      = req_y_coord;
         item_z_in      = req_z_coord;
         item_transp_in = req_transparent;
      end
   end

   // Occupied neighbours, collected as read data returns.
   assign occ_a = rd_info_ff.hit_a && rd_data[rd_info_ff.col_a[COL_W-1:0]];
   assign occ_b = rd_info_ff.hit_b && rd_data[rd_info_ff.col_b[COL_W-1:0]];

   always_comb begin
      occ_in = occ_ff;
      if (start_query) begin
         occ_in = '0;
      end else if (rd_pend_ff) begin
         case (rd_step_ff)
            vfc_pkg::STEP_CENTRE: begin
               occ_in[vfc_pkg::FACE_XP] = occ_a;
               occ_in[vfc_pkg::FACE_XN] = occ_b;
            end
            vfc_pkg::STEP_ZP: occ_in[vfc_pkg::FACE_ZP] = occ_a;
            vfc_pkg::STEP_ZN: occ_in[vfc_pkg::FACE_ZN] = occ_a;
            vfc_pkg::STEP_YP: occ_in[vfc_pkg::FACE_YP] = occ_a;
            vfc_pkg::STEP_YN: occ_in[vfc_pkg::FACE_YN] = occ_a;
            default:          occ_in = occ_ff;
         endcase
      end
   end

   // Output register; a transparent block shows no face.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_face_in  = rsp_face_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_face_in  = item_transp_ff ? '0 : ~occ_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vfc_pkg::ST_SWEEP;
         sweep_ff     <= '0;
         step_ff      <= vfc_pkg::STEP_CENTRE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         step_ff      <= step_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_x_ff      <= item_x_in;
      item_y_ff      <= item_y_in;
      item_z_ff      <= item_z_in;
      item_transp_ff <= item_transp_in;
      rd_step_ff     <= step_ff;
      rd_info_ff     <= nbr;
      occ_ff         <= occ_in;
      rsp_face_ff    <= rsp_face_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_face_visible = rsp_face_ff;

   // A new result appears only when a query has finished.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == vfc_pkg::ST_FINISH))
      else $error("result raised outside the finish state");

   // Read data is only collected for reads issued by a query step.
   a_pend_from_query: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> $past(state_ff == vfc_pkg::ST_QUERY && mem_rd_en))
      else $error("pending read without a query read");

   // The sequencer never reads and writes one row in the same cycle.
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en && mem_wr_addr == nbr_row))
      else $error("read and write of the same row in one cycle");

   // A transparent queried block gives an empty mask.
   a_transp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && item_transp_ff) |=> (rsp_face_ff == '0))
      else $error("transparent block returned visible faces");

endmodule

### tb/voxel_face_cull_top_test.sv
// Self-checking testbench for voxel_face_cull_top: directed and random requests,
// with every face mask compared against an in-bench occupancy map predictor.
// Depends on vfc_pkg and voxel_face_cull_top only.
module voxel_face_cull_top_test;

   localparam int GRID_X = vfc_pkg::DEF_SIZE_X;
   localparam int GRID_Y = vfc_pkg::DEF_SIZE_Y;
   localparam int GRID_Z = vfc_pkg::DEF_SIZE_Z;
   localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;

   // The one action code that the package leaves unnamed; the block ignores it.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int DRAIN_CYCLES  = 24;
   localparam int RANDOM_ITEMS  = 1675;
   localparam int PRESSURE_HOLD = 200;
   localparam int PRESSURE_REQS = 40;

   typedef struct packed {
      logic [1:0] action;
      logic [3:0] x;
      logic [2:0] y;
      logic [3:0] z;
      logic       transparent;
   } voxel_request_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [1:0]                 req_action;
   logic [3:0]                 req_x_coord;
   logic [2:0]                 req_y_coord;
   logic [3:0]                 req_z_coord;
   logic                       req_transparent;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [vfc_pkg::FACE_W-1:0] rsp_face_visible;

   voxel_face_cull_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .req_z_coord      (req_z_coord),
      .req_transparent  (req_transparent),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_face_visible (rsp_face_visible)
   );

   // Predicted occupancy of opaque blocks and the masks still owed by the block.
   bit                         opaque_map [CELLS];
   logic [vfc_pkg::FACE_W-1:0] face_masks_owed [$];
   logic [vfc_pkg::FACE_W-1:0] mask_wanted;

   int  mismatch_count;
   int  cycle_count;
   int  masks_checked;
   int  queries_sent;
   int  adds_sent;
   int  clears_sent;
   int  ignored_sent;
   int  input_stall_cycles;
   int  long_holds_done;
   int  receiver_hold_request;
   bit  sender_idles;
   bit  receiver_idles;

   // Clock with a period of 10.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cycle count and the overall time limit.
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_valid && req_stall)
         input_stall_cycles++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d masks outstanding", cycle_count,
                  face_masks_owed.size());
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   function automatic bit cell_in_grid(int x, int y, int z);
      return x >= 0 && x < GRID_X && y >= 0 && y < GRID_Y && z >= 0 && z < GRID_Z;
   endfunction

   // Cells outside the grid always count as empty.
   function automatic bit opaque_cell(int x, int y, int z);
      if (!cell_in_grid(x, y, z))
         return 1'b0;
      return opaque_map[(z * GRID_Y + y) * GRID_X + x];
   endfunction

   // Updates the predicted map for one accepted request and queues any mask it owes.
   function automatic void apply_request(voxel_request_type r);
      logic [vfc_pkg::FACE_W-1:0] mask;
      int x;
      int y;
      int z;
      x = int'(r.x);
      y = int'(r.y);
      z = int'(r.z);
      mask = '0;
      case (r.action)
         vfc_pkg::ACT_CLEAR: begin
            foreach (opaque_map[i])
               opaque_map[i] = 1'b0;
            clears_sent++;
         end
         vfc_pkg::ACT_ADD: begin
            if (cell_in_grid(x, y, z))
               opaque_map[(z * GRID_Y + y) * GRID_X + x] = !r.transparent;
            adds_sent++;
         end
         vfc_pkg::ACT_QUERY: begin
            // A transparent block renders nothing, so every face stays hidden.
            if (!r.transparent) begin
               mask[vfc_pkg::FACE_ZP] = !opaque_cell(x, y, z + 1);
               mask[vfc_pkg::FACE_XP] = !opaque_cell(x + 1, y, z);
               mask[vfc_pkg::FACE_ZN] = !opaque_cell(x, y, z - 1);
               mask[vfc_pkg::FACE_XN] = !opaque_cell(x - 1, y, z);
               mask[vfc_pkg::FACE_YP] = !opaque_cell(x, y + 1, z);
               mask[vfc_pkg::FACE_YN] = !opaque_cell(x, y - 1, z);
            end
            face_masks_owed.push_back(mask);
            queries_sent++;
         end
         default: begin
            ignored_sent++;
         end
      endcase
   endfunction

   // Offers one request, after a random gap if sender_idles, and waits until taken.
   task automatic send_request(input logic [1:0] action, input int x, input int y,
                               input int z, input bit transparent);
      voxel_request_type r;
      int gap;
      r.action      = action;
      r.x           = 4'(x);
      r.y           = 3'(y);
      r.z           = 4'(z);
      r.transparent = transparent;
      gap = sender_idles ? $urandom_range(0, 10) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= r.action;
      req_x_coord     <= r.x;
      req_y_coord     <= r.y;
      req_z_coord     <= r.z;
      req_transparent <= r.transparent;
      do @(posedge clock); while (req_stall);
      apply_request(r);
   endtask

   // Result side: a hold before each result, random if receiver_idles, long if asked.
   initial begin : result_receiver
      int hold;
      rsp_stall = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (receiver_hold_request > 0) begin
            hold = receiver_hold_request;
            receiver_hold_request = 0;
            long_holds_done++;
         end else begin
            hold = receiver_idles ? $urandom_range(0, 10) : 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   // Each accepted result is compared with the oldest owed mask.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'bx)
         report_mismatch("rsp_valid is unknown");
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (face_masks_owed.size() == 0) begin
            report_mismatch($sformatf("unexpected result, face mask %b", rsp_face_visible));
         end else begin
            mask_wanted = face_masks_owed.pop_front();
            masks_checked++;
            if (rsp_face_visible !== mask_wanted)
               report_mismatch($sformatf("face mask %b, predicted %b", rsp_face_visible,
                                         mask_wanted));
         end
      end
   end

   // A coordinate within spread of a centre, clipped to the field's range.
   function automatic int near(int centre, int spread, int top);
      int v;
      v = centre + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0)
         v = 0;
      if (v > top)
         v = top;
      return v;
   endfunction

   // An empty map leaves every face visible; a transparent block shows none.
   task automatic test_empty_map();
      send_request(vfc_pkg::ACT_QUERY, 0, 0, 0, 1'b0);
      send_request(vfc_pkg::ACT_QUERY, 15, 7, 15, 1'b0);
      send_request(vfc_pkg::ACT_QUERY, 7, 4, 7, 1'b1);
   endtask

   // A block boxed in on all six sides, then opened on one side.
   task automatic test_enclosed_block();
      send_request(vfc_pkg::ACT_ADD, 6, 3, 6, 1'b0);
      send_request(vfc_pkg::ACT_ADD, 6, 3, 7, 1'b0);
      send_request(vfc_pkg::ACT_ADD, 7, 3, 6, 1'b0);
      send_request(vfc_pkg::ACT_ADD, 6, 3, 5, 1'b0);
      send_request(vfc_pkg::ACT_ADD, 5, 3, 6, 1'b0);
      send_request(vfc_pkg::ACT_ADD, 6, 4, 6, 1'b0);
      send_request(vfc_pkg::ACT_ADD, 6, 2, 6, 1'b0);
      send_request(vfc_pkg::ACT_QUERY, 6, 3, 6, 1'b0);
      send_request(vfc_pkg::ACT_QUERY, 6, 3, 6, 1'b1);
      // A transparent add removes the opaque mark on the +x side.
      send_request(vfc_pkg::ACT_ADD, 7, 3, 6, 1'b1);
      send_request(vfc_pkg::ACT_QUERY, 6, 3, 6, 1'b0);
      // The unused action must leave the map alone and return nothing.
      send_request(ACT_UNUSED, 6, 3, 7, 1'b1);
      send_request(vfc_pkg::ACT_QUERY, 6, 3, 6, 1'b0);
   endtask

   // Blocks in opposite corners; neighbours beyond the grid count as empty.
   task automatic test_grid_edges();
      send_request(vfc_pkg::ACT_ADD, 15, 7, 15, 1'b0);
      send_request(vfc_pkg::ACT_ADD, 0, 0, 0, 1'b0);
      send_request(vfc_pkg::ACT_QUERY, 14, 7, 15, 1'b0);
      send_request(vfc_pkg::ACT_QUERY, 0, 0, 1, 1'b0);
      send_request(vfc_pkg::ACT_QUERY, 15, 7, 15, 1'b0);
   endtask

   // A clear empties the whole map.
   task automatic test_clear_map();
      send_request(vfc_pkg::ACT_CLEAR, 0, 0, 0, 1'b0);
      send_request(vfc_pkg::ACT_QUERY, 6, 3, 6, 1'b0);
   endtask

   // The receiver holds off for a long stretch while queries keep coming.
   task automatic test_backpressure();
      int cx;
      int cy;
      int cz;
      cx = $urandom_range(0, 15);
      cy = $urandom_range(0, 7);
      cz = $urandom_range(0, 15);
      for (int i = 0; i < 12; i++)
         send_request(vfc_pkg::ACT_ADD, near(cx, 1, 15), near(cy, 1, 7), near(cz, 1, 15),
                      1'b0);
      sender_idles = 1'b0;
      receiver_hold_request = PRESSURE_HOLD;
      for (int i = 0; i < PRESSURE_REQS; i++)
         send_request(vfc_pkg::ACT_QUERY, near(cx, 1, 15), near(cy, 1, 7), near(cz, 1, 15),
                      $urandom_range(0, 7) == 0);
      sender_idles = 1'b1;
   endtask

   // Clustered adds and queries so that neighbours are often occupied, with
   // occasional requests anywhere on the grid, rare clears and ignored actions.
   task automatic test_random_traffic();
      int counted;
      int left_in_cluster;
      int cx;
      int cy;
      int cz;
      int roll;
      int x;
      int y;
      int z;
      bit t;
      logic [1:0] action;
      counted = 0;
      left_in_cluster = 0;
      while (counted < RANDOM_ITEMS) begin
         // Four quarters: both sides idle, neither, sender only, receiver only.
         sender_idles   = (counted * 4 / RANDOM_ITEMS) inside {0, 2};
         receiver_idles = (counted * 4 / RANDOM_ITEMS) inside {0, 3};
         if (left_in_cluster == 0) begin
            cx = $urandom_range(0, 15);
            cy = $urandom_range(0, 7);
            cz = $urandom_range(0, 15);
            left_in_cluster = $urandom_range(20, 60);
         end
         left_in_cluster--;
         roll = $urandom_range(0, 99);
         if (roll < 1)
            action = vfc_pkg::ACT_CLEAR;
         else if (roll < 5)
            action = ACT_UNUSED;
         else if (roll < 50)
            action = vfc_pkg::ACT_ADD;
         else
            action = vfc_pkg::ACT_QUERY;
         if ($urandom_range(0, 9) == 0) begin
            x = $urandom_range(0, 15);
            y = $urandom_range(0, 7);
            z = $urandom_range(0, 15);
         end else begin
            x = near(cx, 2, 15);
            y = near(cy, 2, 7);
            z = near(cz, 2, 15);
         end
         if (action == vfc_pkg::ACT_ADD)
            t = $urandom_range(0, 3) == 0;
         else if (action == vfc_pkg::ACT_QUERY)
            t = $urandom_range(0, 9) == 0;
         else
            t = 1'($urandom_range(0, 1));
         send_request(action, x, y, z, t);
         counted++;
      end
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // Reset, the test sequence, then the drain and the verdict.
   initial begin : main_sequence
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_action            = vfc_pkg::ACT_CLEAR;
      req_x_coord           = '0;
      req_y_coord           = '0;
      req_z_coord           = '0;
      req_transparent       = 1'b0;
      mismatch_count        = 0;
      cycle_count           = 0;
      masks_checked         = 0;
      queries_sent          = 0;
      adds_sent             = 0;
      clears_sent           = 0;
      ignored_sent          = 0;
      input_stall_cycles    = 0;
      long_holds_done       = 0;
      receiver_hold_request = 0;
      sender_idles          = 1'b1;
      receiver_idles        = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_map();
      test_enclosed_block();
      test_grid_edges();
      test_clear_map();
      test_backpressure();
      test_random_traffic();

      @(negedge clock);
      req_valid <= 1'b0;
      wait (face_masks_owed.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d queries, %0d adds, %0d clears and %0d ignored requests;",
               queries_sent, adds_sent, clears_sent, ignored_sent);
      $display("%0d face masks checked, %0d long receiver holds, %0d cycles of input stall.",
               masks_checked, long_holds_done, input_stall_cycles);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

### sim.f
rtl/vfc_pkg.sv
rtl/vfc_addr_gen.sv
rtl/vfc_row_mem.sv
rtl/voxel_face_cull_top.sv
tb/voxel_face_cull_top_test.sv
